>>> src/indexed_min_heap_by_timestamp_defines.svh
// assertion macros for the indexed min-heap
// no dependencies
`ifndef INDEXED_MIN_HEAP_BY_TIMESTAMP_DEFINES_SVH
`define INDEXED_MIN_HEAP_BY_TIMESTAMP_DEFINES_SVH
`define IMH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define IMH_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> src/imh_pkg.sv
// shared types and codes for the indexed min-heap
// no dependencies
package imh_pkg;
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_DELETE = 2'd1;
  localparam logic [1:0] OP_POP    = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;
  localparam logic [1:0] ST_EMPTY  = 2'd3;
  typedef struct packed {
    logic [1:0]  op;
    logic [9:0]  item_id;
    logic [31:0] item_time;
  } in_t;
  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  min_id;
    logic [31:0] min_time;
    logic [10:0] count;
  } out_t;
endpackage

>>> src/imh_ram.sv
// generic single-port ram with registered read
// no dependencies
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> src/indexed_min_heap_by_timestamp.sv
// Indexed min-heap of ids ordered by timestamp. An operation is taken when start is high and
// busy is low. Its result shows for one cycle with out_valid and cannot be stalled. All slot
// reads and writes go through one single-port slot memory, and that memory sets the timing.
// An insert climbs toward the root level by level. A delete or pop first moves each entry on
// the path above its slot down one level, then sifts the last entry down from the root.
// After reset, busy stays high while a clearing pass over all ID_SPACE entries wipes the
// presence memory.
// depends on imh_pkg, imh_ram and the defines header
`include "indexed_min_heap_by_timestamp_defines.svh"
module indexed_min_heap_by_timestamp #(
  parameter int CAPACITY   = 1024,
  parameter int ID_SPACE   = 1024,
  parameter int TIME_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  imh_pkg::in_t  in_data,
  output logic          out_valid,
  output imh_pkg::out_t out_data
);
  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = IW + TIME_WIDTH;

  localparam logic [4:0] S_CLR = 5'd0, S_IDLE = 5'd1, S_CHK = 5'd2, S_CHK2 = 5'd3,
    S_UPRD = 5'd4, S_UPWT = 5'd5, S_UPCMP = 5'd6, S_LIFTRD = 5'd7, S_LIFTWT = 5'd8,
    S_LIFTWR = 5'd9, S_LASTRD = 5'd10, S_LASTWT = 5'd11, S_DNL = 5'd12, S_DNLW = 5'd13,
    S_DNR = 5'd14, S_DNRW = 5'd15, S_DNCMP = 5'd16, S_PLACE = 5'd17, S_ROOTRD = 5'd18,
    S_ROOTWT = 5'd19, S_DONE = 5'd20, S_ZERO = 5'd21, S_PCLR = 5'd22;

  logic [4:0] st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [SW-1:0] slot_r, slot_nxt, pick_r, pick_nxt;
  logic [IW-1:0] id_r, id_nxt, clr_r, clr_nxt;
  logic [TIME_WIDTH-1:0] t_r, t_nxt, lt_r, lt_nxt;
  logic [IW-1:0] lid_r, lid_nxt;
  logic [1:0] op_r, op_nxt, stat_r, stat_nxt;
  logic hasr_r, hasr_nxt;
  logic [IW-1:0] victim_r, victim_nxt;
  imh_pkg::out_t res_r, res_nxt;
  logic ov_r, ov_nxt;

  logic s_we, p_we, v_we;
  logic [SW-1:0] s_addr, p_wdata, p_rdata;
  logic [EW-1:0] s_wdata, s_rdata;
  logic [IW-1:0] p_addr, v_addr;
  logic v_wdata, v_rdata;

  imh_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_slots (.clk(clk), .we(s_we), .addr(s_addr),
    .wdata(s_wdata), .rdata(s_rdata));
  imh_ram #(.WIDTH(SW), .DEPTH(ID_SPACE)) u_pos (.clk(clk), .we(p_we), .addr(p_addr),
    .wdata(p_wdata), .rdata(p_rdata));
  imh_ram #(.WIDTH(1), .DEPTH(ID_SPACE)) u_vld (.clk(clk), .we(v_we), .addr(v_addr),
    .wdata(v_wdata), .rdata(v_rdata));

  logic [IW-1:0] rd_id;
  logic [TIME_WIDTH-1:0] rd_t;
  logic [SW-1:0] parent, left, right;
  logic id_ok;
  logic [SW:0] left_w, right_w;
  assign rd_id  = s_rdata[EW-1:TIME_WIDTH];
  assign rd_t   = s_rdata[TIME_WIDTH-1:0];
  assign parent = SW'((slot_r - SW'(1)) >> 1);
  assign left_w  = {slot_r, 1'b1};
  assign right_w = left_w + (SW+1)'(1);
  assign left  = left_w[SW-1:0];
  assign right = right_w[SW-1:0];
  assign id_ok = (32'(in_data.item_id) < 32'(ID_SPACE));

  assign busy = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign out_data = res_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; slot_nxt = slot_r; pick_nxt = pick_r; id_nxt = id_r;
    clr_nxt = clr_r; t_nxt = t_r; lt_nxt = lt_r; lid_nxt = lid_r; op_nxt = op_r;
    stat_nxt = stat_r; hasr_nxt = hasr_r; victim_nxt = victim_r; res_nxt = res_r;
    ov_nxt = 1'b0;
    s_we = 1'b0; s_addr = slot_r; s_wdata = {id_r, t_r};
    p_we = 1'b0; p_addr = id_r; p_wdata = slot_r;
    v_we = 1'b0; v_addr = id_r; v_wdata = 1'b0;
    unique case (st_r)
      S_CLR: begin
        v_we = 1'b1; v_addr = clr_r; v_wdata = 1'b0;
        clr_nxt = clr_r + IW'(1);
        if (32'(clr_r) == ID_SPACE - 1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          op_nxt = in_data.op; id_nxt = in_data.item_id;
          t_nxt = TIME_WIDTH'(in_data.item_time); stat_nxt = imh_pkg::ST_OK;
          if (in_data.op == imh_pkg::OP_POP) begin
            if (cnt_r == '0) begin
              stat_nxt = imh_pkg::ST_EMPTY; st_nxt = S_ROOTRD;
            end else begin
              slot_nxt = '0; s_addr = '0; st_nxt = S_LIFTWT; pick_nxt = '0;
            end
          end else if (in_data.op == imh_pkg::OP_NOP) begin
            st_nxt = S_ROOTRD;
          end else if (!id_ok) begin
            stat_nxt = imh_pkg::ST_ABSENT; st_nxt = S_ROOTRD;
          end else begin
            v_addr = in_data.item_id; p_addr = in_data.item_id; st_nxt = S_CHK;
          end
        end
      end
      S_CHK: begin
        if (op_r == imh_pkg::OP_INSERT) begin
          if (v_rdata) st_nxt = S_ROOTRD;
          else if (32'(cnt_r) >= CAPACITY) begin
            stat_nxt = imh_pkg::ST_FULL; st_nxt = S_ROOTRD;
          end else begin
            v_we = 1'b1; v_wdata = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            slot_nxt = SW'(cnt_r);
            st_nxt = (cnt_r == '0) ? S_PLACE : S_UPRD;
          end
        end else begin
          if (!v_rdata || CW'(p_rdata) >= cnt_r) begin
            stat_nxt = imh_pkg::ST_ABSENT; st_nxt = S_ROOTRD;
          end else begin
            slot_nxt = p_rdata; s_addr = p_rdata; st_nxt = S_LIFTWT;
          end
        end
      end
      S_UPRD: begin
        s_addr = parent; st_nxt = S_UPWT;
      end
      S_UPWT: begin
        s_addr = parent; st_nxt = S_UPCMP;
      end
      S_UPCMP: begin
        if (t_r < rd_t) begin
          s_we = 1'b1; s_wdata = s_rdata;
          p_we = 1'b1; p_addr = rd_id; p_wdata = slot_r;
          slot_nxt = parent;
          st_nxt = (parent == '0) ? S_PLACE : S_UPRD;
        end else st_nxt = S_PLACE;
      end
      S_LIFTWT: st_nxt = S_CHK2;
      S_CHK2: begin
        victim_nxt = rd_id;
        st_nxt = (slot_r == '0) ? S_LASTRD : S_LIFTRD;
      end
      S_LIFTRD: begin
        s_addr = parent; st_nxt = S_LIFTWR; pick_nxt = parent;
      end
      S_LIFTWR: begin
        s_we = 1'b1; s_wdata = s_rdata;
        p_we = 1'b1; p_addr = rd_id; p_wdata = slot_r;
        slot_nxt = pick_r;
        st_nxt = (pick_r == '0) ? S_LASTRD : S_LIFTRD;
      end
      S_LASTRD: begin
        v_we = 1'b1; v_addr = victim_r; v_wdata = 1'b0;
        cnt_nxt = cnt_r - CW'(1);
        s_addr = SW'(cnt_r - CW'(1));
        slot_nxt = '0;
        st_nxt = (cnt_r == CW'(1)) ? S_ROOTRD : S_LASTWT;
      end
      S_LASTWT: begin
        s_addr = SW'(cnt_r); st_nxt = S_ZERO;
      end
      S_ZERO: begin
        id_nxt = rd_id; t_nxt = rd_t; st_nxt = S_DNL;
      end
      S_DNL: begin
        if (left_w >= (SW+1)'(cnt_r)) st_nxt = S_PLACE;
        else begin
          s_addr = left; hasr_nxt = right_w < (SW+1)'(cnt_r); st_nxt = S_DNLW;
        end
      end
      S_DNLW: begin
        s_addr = left; st_nxt = S_DNR;
      end
      S_DNR: begin
        lid_nxt = rd_id; lt_nxt = rd_t; s_addr = right; st_nxt = S_DNRW;
      end
      S_DNRW: begin
        s_addr = right; st_nxt = S_DNCMP;
      end
      S_DNCMP: begin
        if (lt_r < t_r) begin
          if (hasr_r && rd_t < lt_r) pick_nxt = right;
          else pick_nxt = left;
          st_nxt = S_PCLR;
        end else if (hasr_r && rd_t < t_r) begin
          pick_nxt = right; st_nxt = S_PCLR;
        end else st_nxt = S_PLACE;
        if (hasr_r && rd_t < lt_r && (lt_r < t_r || rd_t < t_r)) begin
          lid_nxt = rd_id; lt_nxt = rd_t;
        end
      end
      S_PCLR: begin
        s_we = 1'b1; s_wdata = {lid_r, lt_r};
        p_we = 1'b1; p_addr = lid_r; p_wdata = slot_r;
        slot_nxt = pick_r; st_nxt = S_DNL;
      end
      S_PLACE: begin
        s_we = 1'b1; p_we = 1'b1; st_nxt = S_ROOTRD;
      end
      S_ROOTRD: begin
        s_addr = '0; st_nxt = S_ROOTWT;
      end
      S_ROOTWT: begin
        s_addr = '0; st_nxt = S_DONE;
      end
      S_DONE: begin
        res_nxt.status = stat_r;
        res_nxt.count = 11'(cnt_r);
        res_nxt.min_id = (cnt_r == '0) ? '0 : 10'(rd_id);
        res_nxt.min_time = (cnt_r == '0) ? '0 : 32'(rd_t);
        ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; cnt_r <= '0; clr_r <= '0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; clr_r <= clr_nxt; ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt; pick_r <= pick_nxt; id_r <= id_nxt; t_r <= t_nxt; lt_r <= lt_nxt;
    lid_r <= lid_nxt; op_r <= op_nxt; stat_r <= stat_nxt; hasr_r <= hasr_nxt;
    victim_r <= victim_nxt; res_r <= res_nxt;
  end

  `IMH_ASSERT(a_cnt_cap, clk, rst_n, (32'(cnt_r) <= CAPACITY), "count above capacity")
  `IMH_ASSERT(a_ov_once, clk, rst_n, (ov_r |=> !ov_r), "result strobe held two cycles")
  `IMH_ASSERT(a_ov_idle, clk, rst_n, (ov_r |-> st_r == S_IDLE), "result while busy")
  `IMH_ASSERT(a_start_busy, clk, rst_n, ((start && !busy) |=> busy), "transfer not taken")
endmodule
